@@ rtl/elevator_order_scheduler_defines.svh @@
// Assertion macros shared by the elevator order scheduler RTL.
`ifndef ELEVATOR_ORDER_SCHEDULER_DEFINES_SVH
`define ELEVATOR_ORDER_SCHEDULER_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define EOS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define EOS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/eos_pkg.sv @@
// Package: codes, field widths and beat types of the elevator order scheduler.
`default_nettype none
package eos_pkg;

  localparam int NumFloorsDef = 4;
  localparam int MaxFloors    = 16;
  localparam int LampW        = 4;
  localparam int CmdW         = 2;
  localparam int KindW        = 2;
  localparam int FloorW       = 2;
  localparam int DirW         = 2;

  typedef logic [CmdW-1:0]   cmd_t;
  typedef logic [KindW-1:0]  kind_t;
  typedef logic [FloorW-1:0] floor_t;
  typedef logic [DirW-1:0]   dir_t;
  typedef logic [LampW-1:0]  lamp_t;

  localparam cmd_t CMD_QUERY = 2'd0;
  localparam cmd_t CMD_PRESS = 2'd1;
  localparam cmd_t CMD_SERVE = 2'd2;
  localparam cmd_t CMD_CLEAR = 2'd3;

  localparam kind_t BTN_HALL_UP   = 2'd0;
  localparam kind_t BTN_HALL_DOWN = 2'd1;
  localparam kind_t BTN_CAB       = 2'd2;

  localparam dir_t DIR_STOP = 2'd0;
  localparam dir_t DIR_UP   = 2'd1;
  localparam dir_t DIR_DOWN = 2'd2;

  typedef struct packed {
    cmd_t   cmd;
    kind_t  button_kind;
    floor_t button_floor;
    floor_t car_floor;
    logic   car_between;
    dir_t   car_direction;
  } eos_item_t;

  typedef struct packed {
    dir_t  next_direction;
    logic  should_stop;
    logic  no_orders;
    logic  order_here;
    lamp_t lamp_up;
    lamp_t lamp_down;
    lamp_t lamp_cab;
  } eos_result_t;

endpackage
`default_nettype wire

@@ rtl/eos_in_if.sv @@
// Interface: input channel carrying one command beat.
`default_nettype none
interface eos_in_if;
  import eos_pkg::*;

  logic   valid;
  logic   ready;
  cmd_t   cmd;
  kind_t  button_kind;
  floor_t button_floor;
  floor_t car_floor;
  logic   car_between;
  dir_t   car_direction;

  modport source (
    output valid, cmd, button_kind, button_floor, car_floor, car_between, car_direction,
    input  ready
  );
  modport sink (
    input  valid, cmd, button_kind, button_floor, car_floor, car_between, car_direction,
    output ready
  );
endinterface
`default_nettype wire

@@ rtl/eos_out_if.sv @@
// Interface: result channel carrying one scheduler decision beat.
`default_nettype none
interface eos_out_if;
  import eos_pkg::*;

  logic  valid;
  logic  ready;
  dir_t  next_direction;
  logic  should_stop;
  logic  no_orders;
  logic  order_here;
  lamp_t lamp_up;
  lamp_t lamp_down;
  lamp_t lamp_cab;

  modport source (
    output valid, next_direction, should_stop, no_orders, order_here,
           lamp_up, lamp_down, lamp_cab,
    input  ready
  );
  modport sink (
    input  valid, next_direction, should_stop, no_orders, order_here,
           lamp_up, lamp_down, lamp_cab,
    output ready
  );
endinterface
`default_nettype wire

@@ rtl/elevator_order_scheduler.sv @@
// Top level: elevator order store, direction decider and stop logic.
`default_nettype none
// Elevator order scheduler. Each input beat may press a button, serve the car's
// floor, clear all orders or just query; the block then returns one result beat
// with the next motor direction, the stop decision at the car's floor, the
// empty-orders flag, the order-at-floor flag and the three lamp masks, all
// computed from the orders after that beat's update. A beat is captured in an
// input register, the order update and decision run in one short combinational
// pass, and the result lands in an output register; one beat per cycle is
// sustained while the result is taken, set by the read-modify-write of the
// order masks. in_ch.ready drops only while both registers are full and the
// result is not taken. Lamp outputs show floors 0 to 3 only.
module elevator_order_scheduler #(
  parameter int NUM_FLOORS = eos_pkg::NumFloorsDef
) (
  input  wire     clk,
  input  wire     rst_n,
  eos_in_if.sink    in_ch,
  eos_out_if.source out_ch
);
  import eos_pkg::*;
  `include "elevator_order_scheduler_defines.svh"

  typedef logic [NUM_FLOORS-1:0] mask_t;

  localparam mask_t FloorOne = {{(NUM_FLOORS-1){1'b0}}, 1'b1};

  // Pipeline control and payload.
  logic        s1_valid_r;
  eos_item_t   s1_r;
  logic        out_valid_r;
  eos_result_t out_r;
  logic        out_take;
  logic        s1_adv;

  // Order and lamp state.
  mask_t up_orders_r, down_orders_r, up_lamps_r, down_lamps_r, cab_lamps_r;
  mask_t up_orders_nxt, down_orders_nxt, up_lamps_nxt, down_lamps_nxt, cab_lamps_nxt;

  // Decision signals.
  logic        fl_in_range, bfl_in_range;
  mask_t       here_bit, btn_bit, all_orders, below_mask, below, above;
  logic        here, stop;
  dir_t        nd;
  logic [MaxFloors-1:0] lamp_up_wide, lamp_down_wide, lamp_cab_wide;
  eos_result_t res;

  // Output register frees when empty or being drained; input stage advances into it.
  assign out_take    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && out_take;
  assign in_ch.ready = !s1_valid_r || out_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // Capture the beat; payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_r.cmd           <= in_ch.cmd;
      s1_r.button_kind   <= in_ch.button_kind;
      s1_r.button_floor  <= in_ch.button_floor;
      s1_r.car_floor     <= in_ch.car_floor;
      s1_r.car_between   <= in_ch.car_between;
      s1_r.car_direction <= in_ch.car_direction;
    end
  end

  // Order update: apply the command of the beat in the input register.
  always_comb begin
    fl_in_range  = int'(s1_r.car_floor) < NUM_FLOORS;
    bfl_in_range = int'(s1_r.button_floor) < NUM_FLOORS;
    here_bit     = fl_in_range ? (FloorOne << s1_r.car_floor) : '0;
    btn_bit      = FloorOne << s1_r.button_floor;

    up_orders_nxt   = up_orders_r;
    down_orders_nxt = down_orders_r;
    up_lamps_nxt    = up_lamps_r;
    down_lamps_nxt  = down_lamps_r;
    cab_lamps_nxt   = cab_lamps_r;

    case (s1_r.cmd)
      CMD_PRESS: begin
        if (bfl_in_range) begin
          case (s1_r.button_kind)
            BTN_HALL_UP: begin
              // No up button at the top floor.
              if (int'(s1_r.button_floor) != NUM_FLOORS - 1) begin
                up_orders_nxt = up_orders_r | btn_bit;
                up_lamps_nxt  = up_lamps_r | btn_bit;
              end
            end
            BTN_HALL_DOWN: begin
              // No down button at the ground floor.
              if (s1_r.button_floor != '0) begin
                down_orders_nxt = down_orders_r | btn_bit;
                down_lamps_nxt  = down_lamps_r | btn_bit;
              end
            end
            BTN_CAB: begin
              up_orders_nxt   = up_orders_r | btn_bit;
              down_orders_nxt = down_orders_r | btn_bit;
              cab_lamps_nxt   = cab_lamps_r | btn_bit;
            end
            default: ;
          endcase
        end
      end
      CMD_SERVE: begin
        // Serve only when standing at a valid floor.
        if (!s1_r.car_between) begin
          up_orders_nxt   = up_orders_r & ~here_bit;
          down_orders_nxt = down_orders_r & ~here_bit;
          up_lamps_nxt    = up_lamps_r & ~here_bit;
          down_lamps_nxt  = down_lamps_r & ~here_bit;
          cab_lamps_nxt   = cab_lamps_r & ~here_bit;
        end
      end
      CMD_CLEAR: begin
        up_orders_nxt   = '0;
        down_orders_nxt = '0;
        up_lamps_nxt    = '0;
        down_lamps_nxt  = '0;
        cab_lamps_nxt   = '0;
      end
      default: ;
    endcase
  end

  // Direction and stop decision from the updated orders.
  always_comb begin
    all_orders = up_orders_nxt | down_orders_nxt;
    below_mask = here_bit - FloorOne;
    // A car floor beyond the shaft sees every order below it.
    below      = fl_in_range ? (all_orders & below_mask) : all_orders;
    above      = fl_in_range ? (all_orders & ~(below_mask | here_bit)) : '0;
    here       = |(all_orders & here_bit);

    case (s1_r.car_direction)
      DIR_UP: begin
        nd = (|above) ? DIR_UP : ((|below) ? DIR_DOWN : DIR_STOP);
      end
      DIR_DOWN: begin
        nd = (|below) ? DIR_DOWN : ((|above) ? DIR_UP : DIR_STOP);
      end
      default: begin
        // Stopped, or an unknown code: an order at the floor below goes down first.
        if (here && s1_r.car_between) begin
          nd = DIR_DOWN;
        end else begin
          nd = (|above) ? DIR_UP : ((|below) ? DIR_DOWN : DIR_STOP);
        end
      end
    endcase

    stop = 1'b0;
    if (!s1_r.car_between && fl_in_range) begin
      if (s1_r.car_floor == '0 || int'(s1_r.car_floor) == NUM_FLOORS - 1) begin
        stop = here;
      end else if (s1_r.car_direction == DIR_UP) begin
        if (|(up_orders_nxt & here_bit)) begin
          stop = 1'b1;
        end else if (|(down_orders_nxt & here_bit)) begin
          stop = ~|above;
        end
      end else if (s1_r.car_direction == DIR_DOWN) begin
        if (|(down_orders_nxt & here_bit)) begin
          stop = 1'b1;
        end else if (|(up_orders_nxt & here_bit)) begin
          stop = ~|below;
        end
      end
    end

    lamp_up_wide   = MaxFloors'(up_lamps_nxt);
    lamp_down_wide = MaxFloors'(down_lamps_nxt);
    lamp_cab_wide  = MaxFloors'(cab_lamps_nxt);

    res.next_direction = nd;
    res.should_stop    = stop;
    res.no_orders      = ~|all_orders;
    res.order_here     = !s1_r.car_between && here;
    res.lamp_up        = lamp_up_wide[LampW-1:0];
    res.lamp_down      = lamp_down_wide[LampW-1:0];
    res.lamp_cab       = lamp_cab_wide[LampW-1:0];
  end

  // Commit the order update as the beat moves to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_orders_r   <= '0;
      down_orders_r <= '0;
      up_lamps_r    <= '0;
      down_lamps_r  <= '0;
      cab_lamps_r   <= '0;
    end else if (s1_adv) begin
      up_orders_r   <= up_orders_nxt;
      down_orders_r <= down_orders_nxt;
      up_lamps_r    <= up_lamps_nxt;
      down_lamps_r  <= down_lamps_nxt;
      cab_lamps_r   <= cab_lamps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.next_direction = out_r.next_direction;
  assign out_ch.should_stop    = out_r.should_stop;
  assign out_ch.no_orders      = out_r.no_orders;
  assign out_ch.order_here     = out_r.order_here;
  assign out_ch.lamp_up        = out_r.lamp_up;
  assign out_ch.lamp_down      = out_r.lamp_down;
  assign out_ch.lamp_cab       = out_r.lamp_cab;

  // A lit lamp always has its order pending.
  `EOS_ASSERT_ALWAYS(a_lamps_have_orders,
    ((up_lamps_r & ~up_orders_r) == '0) && ((down_lamps_r & ~down_orders_r) == '0) &&
    ((cab_lamps_r & ~(up_orders_r & down_orders_r)) == '0), "lamp lit without order")
  // A clear beat empties the whole store.
  `EOS_ASSERT_NEXT(a_clear_empties, s1_adv && (s1_r.cmd == CMD_CLEAR),
    (up_orders_r == '0) && (down_orders_r == '0) && (cab_lamps_r == '0),
    "orders left after clear")
  // A stop is only requested at a floor holding an order.
  `EOS_ASSERT_ALWAYS(a_stop_needs_order,
    !out_valid_r || !out_r.should_stop || out_r.order_here, "stop without order here")
  // With no orders the car has nowhere to go.
  `EOS_ASSERT_ALWAYS(a_idle_when_empty,
    !out_valid_r || !out_r.no_orders || (out_r.next_direction == DIR_STOP),
    "direction chosen with no orders")

endmodule
`default_nettype wire
